// ===== hdl/gfm_pkg.sv =====
// ----------------------------------------------------------------------------
// gfm_pkg
// Types, constants and field helpers for the GF(2^64) multiply/invert unit.
// ----------------------------------------------------------------------------
package gfm_pkg;

    localparam int unsigned ElemW = 64;
    localparam int unsigned HalfW = 32;
    localparam int unsigned NumSteps = 10;

    // Low part of the reduction polynomial x^64 + x^4 + x^3 + x + 1.
    localparam logic [7:0] RedLow = 8'h1b;

    localparam logic KindMul = 1'b0;
    localparam logic KindInv = 1'b1;

    typedef logic [ElemW-1:0] t_elem;
    typedef logic [ElemW-1:0][ElemW-1:0] t_mat;

    // Side information that travels with an item down the pipeline.
    typedef struct packed {
        logic  kind;
        logic  zero;
        t_elem a;
    } t_meta;

    function automatic logic [2*HalfW-2:0] clmul32(input logic [HalfW-1:0] x,
                                                   input logic [HalfW-1:0] y);
        logic [2*HalfW-2:0] r;
        r = '0;
        for (int i = 0; i < HalfW; i++) begin
            if (y[i]) begin
                r = r ^ ({{(HalfW-1){1'b0}}, x} << i);
            end
        end
        return r;
    endfunction

    // Folds a 128-bit carry-less product back into the field.
    function automatic t_elem reduce(input logic [2*ElemW-1:0] p);
        logic [ElemW+3:0] h;
        logic [ElemW+3:0] t;
        logic [3:0]       t2;
        t_elem            r;
        h  = {4'b0, p[2*ElemW-1:ElemW]};
        t  = h ^ (h << 1) ^ (h << 3) ^ (h << 4);
        t2 = t[ElemW+3:ElemW];
        r  = p[ElemW-1:0] ^ t[ElemW-1:0];
        r  = r ^ {56'b0, {4'b0, t2} ^ ({4'b0, t2} << 1) ^ ({4'b0, t2} << 3)
                   ^ ({4'b0, t2} << 4)};
        return r;
    endfunction

    function automatic t_elem gf_sqr(input t_elem v);
        logic [2*ElemW-1:0] s;
        s = '0;
        for (int i = 0; i < ElemW; i++) begin
            s[2*i] = v[i];
        end
        return reduce(s);
    endfunction

    // Column j holds x^j raised to the power 2^k; used only at elaboration.
    function automatic t_mat frob_mat(input int k);
        t_mat  m;
        t_elem v;
        for (int j = 0; j < ElemW; j++) begin
            v = t_elem'(1) << j;
            for (int s = 0; s < k; s++) begin
                v = gf_sqr(v);
            end
            m[j] = v;
        end
        return m;
    endfunction

    function automatic t_elem mat_apply(input t_mat m, input t_elem x);
        t_elem r;
        r = '0;
        for (int j = 0; j < ElemW; j++) begin
            if (x[j]) begin
                r = r ^ m[j];
            end
        end
        return r;
    endfunction

endpackage

// ===== hdl/gf2_64_multiply_inverse.sv =====
// ----------------------------------------------------------------------------
// gf2_64_multiply_inverse
// GF(2^64) multiplier and inverter, polynomial x^64 + x^4 + x^3 + x + 1.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                         | tuser
//  s_*     | in  | operand_a[63:0], operand_b    | kind (0 mul, 1 invert)
//  m_*     | out | product[63:0]                 | zero_inverse
//
// One item enters per cycle while the output is not stalled and passes 31
// register stages: ten multiply steps of three stages (Itoh-Tsujii chain for
// the inverse) and a final squaring register.
// Reset clears all valid bits.
// When a waiting result is not taken the whole pipeline holds; nothing is
// dropped or repeated.
module gf2_64_multiply_inverse (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // operand_a, operand_b
    input  logic         s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // product
    output logic         m_tuser    // zero_inverse
);

    localparam int unsigned N = gfm_pkg::NumSteps;

    logic                 ce;
    logic [N:0]           valid_c;
    gfm_pkg::t_elem [N:0] x_c;
    gfm_pkg::t_meta [N:0] meta_c;
    logic                 r_valid;
    gfm_pkg::t_elem       r_prod;
    logic                 r_zero;

    assign ce       = !r_valid || m_tready;
    assign s_tready = ce;

    assign valid_c[0]     = s_tvalid;
    assign x_c[0]         = s_tdata[63:0];
    assign meta_c[0].kind = s_tuser;
    assign meta_c[0].a    = s_tdata[63:0];
    assign meta_c[0].zero = (s_tuser == gfm_pkg::KindInv) && (s_tdata[63:0] == '0);

    // Even steps double the run of ones, a^(2^n-1) to a^(2^(2n)-1); odd steps append one factor a.
    for (genvar g = 0; g < N; g++) begin : g_step
        gfm_step #(
            .K     ((g % 2 == 0) ? ((2 << (g / 2)) - 1) : 1),
            .USE_A ((g % 2) == 1)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (ce),
            .i_valid (valid_c[g]),
            .i_x     (x_c[g]),
            .i_vmul  ((g == 0) ? s_tdata[127:64] : gfm_pkg::t_elem'(1)),
            .i_meta  (meta_c[g]),
            .o_valid (valid_c[g+1]),
            .o_x     (x_c[g+1]),
            .o_meta  (meta_c[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ce) begin
            r_valid <= valid_c[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_prod <= (meta_c[N].kind == gfm_pkg::KindInv) ? gfm_pkg::gf_sqr(x_c[N])
                                                           : x_c[N];
            r_zero <= meta_c[N].zero;
        end
    end

    assign m_tvalid = r_valid;
    assign m_tdata  = r_prod;
    assign m_tuser  = r_zero;

endmodule

// ===== hdl/gfm_step.sv =====
// ----------------------------------------------------------------------------
// gfm_step
// One field multiply in three stages: Frobenius power, partial products,
// combine and reduce.
// ----------------------------------------------------------------------------
module gfm_step #(
    parameter int K     = 1,
    parameter bit USE_A = 1'b0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_ce,
    input  logic           i_valid,
    input  gfm_pkg::t_elem i_x,
    input  gfm_pkg::t_elem i_vmul,
    input  gfm_pkg::t_meta i_meta,
    output logic           o_valid,
    output gfm_pkg::t_elem o_x,
    output gfm_pkg::t_meta o_meta
);

    localparam gfm_pkg::t_mat Frob = gfm_pkg::frob_mat(K);
    localparam int unsigned H = gfm_pkg::HalfW;

    logic [2:0]          r_valid;
    gfm_pkg::t_meta      r_meta1, r_meta2, r_meta3;
    gfm_pkg::t_elem      r_u, r_v, r_x;
    logic [2*H-2:0]      r_ll, r_lh, r_hl, r_hh;
    gfm_pkg::t_elem      n_u, n_v;
    logic [2*gfm_pkg::ElemW-1:0] n_p;

    // Multiply items only take the step's own operand (b or one).
    always_comb begin
        if (i_meta.kind == gfm_pkg::KindInv) begin
            n_u = gfm_pkg::mat_apply(Frob, i_x);
            n_v = USE_A ? i_meta.a : i_x;
        end else begin
            n_u = i_x;
            n_v = i_vmul;
        end
    end

    // The high partial product sits at bit 64, the two cross products at bit 32.
    always_comb begin
        n_p = {1'b0, r_hh, 64'b0}
            ^ {33'b0, (r_lh ^ r_hl), 32'b0}
            ^ {65'b0, r_ll};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ce) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_u     <= n_u;
            r_v     <= n_v;
            r_meta1 <= i_meta;
            r_ll    <= gfm_pkg::clmul32(r_u[H-1:0], r_v[H-1:0]);
            r_lh    <= gfm_pkg::clmul32(r_u[H-1:0], r_v[2*H-1:H]);
            r_hl    <= gfm_pkg::clmul32(r_u[2*H-1:H], r_v[H-1:0]);
            r_hh    <= gfm_pkg::clmul32(r_u[2*H-1:H], r_v[2*H-1:H]);
            r_meta2 <= r_meta1;
            r_x     <= gfm_pkg::reduce(n_p);
            r_meta3 <= r_meta2;
        end
    end

    assign o_valid = r_valid[2];
    assign o_x     = r_x;
    assign o_meta  = r_meta3;

endmodule

// ===== hdl/gfm_checker.sv =====
// ----------------------------------------------------------------------------
// gfm_checker
// Port-level checks for the GF(2^64) unit, bound to the top level.
// ----------------------------------------------------------------------------
module gfm_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [63:0]  m_tdata,
    input logic         m_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser |-> m_tdata == 64'd0)
        else $error("zero inverse flagged with nonzero data");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind gf2_64_multiply_inverse gfm_checker u_gfm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== dv/gf2_64_multiply_inverse_checker.sv =====
// ----------------------------------------------------------------------------
// gf2_64_multiply_inverse_checker
// Watches both channels, predicts each field result and compares in order.
// ----------------------------------------------------------------------------
module gf2_64_multiply_inverse_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [127:0] i_s_tdata,
    input  logic         i_s_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [63:0]  i_m_tdata,
    input  logic         i_m_tuser,
    output int           o_errors,
    output int           o_pending
);

    typedef struct packed {
        logic           zero_inverse;
        gfm_pkg::t_elem product;
    } t_answer;

    t_answer expected_answers[$];

    function automatic gfm_pkg::t_elem field_mul(input gfm_pkg::t_elem x,
                                                 input gfm_pkg::t_elem y);
        gfm_pkg::t_elem acc;
        acc = '0;
        for (int i = 0; i < 64; i++) begin
            if (y[i]) begin
                acc = acc ^ x;
            end
            x = {x[62:0], 1'b0} ^ (x[63] ? {56'b0, gfm_pkg::RedLow} : 64'h0);
        end
        return acc;
    endfunction

    // Raises x to 2^64 - 2 by square-and-multiply.
    function automatic gfm_pkg::t_elem field_inv(input gfm_pkg::t_elem x);
        gfm_pkg::t_elem acc;
        gfm_pkg::t_elem base;
        acc = 64'd1;
        base = field_mul(x, x);
        for (int i = 1; i < 64; i++) begin
            acc = field_mul(acc, base);
            base = field_mul(base, base);
        end
        return acc;
    endfunction

    function automatic t_answer predict_answer(input logic kind, input gfm_pkg::t_elem a,
                                               input gfm_pkg::t_elem b);
        t_answer r;
        if (kind == gfm_pkg::KindMul) begin
            r.product = field_mul(a, b);
            r.zero_inverse = 1'b0;
        end else if (a == '0) begin
            r.product = '0;
            r.zero_inverse = 1'b1;
        end else begin
            r.product = field_inv(a);
            r.zero_inverse = 1'b0;
        end
        return r;
    endfunction

    initial o_errors = 0;
    assign o_pending = expected_answers.size();

    always @(posedge i_clk) begin
        t_answer want;
        int      bad;
        bad = 0;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                expected_answers.insert(expected_answers.size(),
                                        predict_answer(i_s_tuser, i_s_tdata[63:0],
                                                       i_s_tdata[127:64]));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_answers.size() == 0) begin
                    $error("result transfer with nothing expected: %h", i_m_tdata);
                    bad = bad + 1;
                end else begin
                    want = expected_answers.pop_front();
                    if (want.product !== i_m_tdata) begin
                        $error("product expected %h actual %h", want.product, i_m_tdata);
                        bad = bad + 1;
                    end
                    if (want.zero_inverse !== i_m_tuser) begin
                        $error("zero_inverse expected %b actual %b", want.zero_inverse,
                               i_m_tuser);
                        bad = bad + 1;
                    end
                end
            end
            if (bad != 0) begin
                o_errors <= o_errors + bad;
            end
        end
    end

endmodule

// ===== dv/gf2_64_multiply_inverse_test.sv =====
// ----------------------------------------------------------------------------
// gf2_64_multiply_inverse_test
// Drives directed and random multiply/invert items with random stalls on both
// sides; the checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module gf2_64_multiply_inverse_test;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;   // operand_a, operand_b
    logic         s_tuser = 1'b0; // kind
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;        // product
    logic         m_tuser;        // zero_inverse
    int           errors;
    int           pending;
    int           cycles = 0;
    int           send_idle = 0;
    int           take_idle = 0;

    localparam int NumRandom = 1700;
    localparam int CycleLimit = 200000;

    gf2_64_multiply_inverse dut (.*);

    gf2_64_multiply_inverse_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_s_tuser(s_tuser), .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser), .o_errors(errors),
        .o_pending(pending)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("[gf2_64_multiply_inverse] ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= take_idle);
    end

    function automatic gfm_pkg::t_elem random_elem();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return gfm_pkg::t_elem'(1) << $urandom_range(63);
            3: return gfm_pkg::t_elem'($urandom_range(255));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Holds one item until it is transferred, with random gaps before it.
    task automatic send_item(input logic kind, input gfm_pkg::t_elem a,
                             input gfm_pkg::t_elem b);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {b, a};
        do @(posedge i_clk); while (!s_tready);
    endtask

    initial begin
        gfm_pkg::t_elem directed[8];
        directed = '{'0, '1, 64'd1, 64'd2, 64'h8000_0000_0000_0000,
                     64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 64'h1b};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < 8; i++) begin
            send_item(gfm_pkg::KindMul, directed[i], directed[7 - i]);
            send_item(gfm_pkg::KindInv, directed[i], directed[(i + 3) % 8]);
        end
        send_item(gfm_pkg::KindMul, '1, '1);
        for (int p = 0; p < 3; p++) begin
            send_idle = (p == 0) ? 33 : (p == 1) ? 46 : 0;
            take_idle = (p == 0) ? 46 : (p == 1) ? 33 : 0;
            for (int i = 0; i < NumRandom / 3; i++) begin
                send_item(1'($urandom_range(1)), random_elem(), random_elem());
                if (i == 100) begin
                    s_tvalid <= 1'b0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
            end
        end
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("[gf2_64_multiply_inverse] OK");
        end else begin
            $display("[gf2_64_multiply_inverse] ERROR");
        end
        $finish;
    end

endmodule

// ===== gf2_64_multiply_inverse.f =====
hdl/gfm_pkg.sv
hdl/gfm_step.sv
hdl/gf2_64_multiply_inverse.sv
hdl/gfm_checker.sv
dv/gf2_64_multiply_inverse_checker.sv
dv/gf2_64_multiply_inverse_test.sv
